### design/rbba_pkg.sv
// rbba_pkg: widths, command and status codes and ring constants
// for the ring buffer block allocator; no dependencies
package rbba_pkg;

	localparam int OFS_W       = 21;
	localparam int SIZE_W      = 21;
	localparam int ADDR_W      = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int MAX_BYTES   = 1048576;
	localparam int GRAIN_BYTES = 64;

	typedef enum logic [2:0] {
		CMD_ALLOC     = 3'd0,
		CMD_FREE      = 3'd1,
		CMD_UNALLOC   = 3'd2,
		CMD_RESET     = 3'd3,
		CMD_TAKE_READ = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_TOO_BIG = 2'd1,
		STATUS_RETRY   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_ADDR = 1'd0,
		CFG_CAPACITY  = 1'd1
	} cfg_idx_t;

endpackage

### design/rbba_if.sv
// rbba channel interfaces: command, result and configuration write
// depends on rbba_pkg for widths and codes
interface rbba_cmd_if;
	logic                         valid;
	logic                         ready;
	rbba_pkg::cmd_t               cmd;
	logic [rbba_pkg::SIZE_W-1:0]  size_bytes;

	modport source (output valid, output cmd, output size_bytes, input ready);
	modport sink   (input valid, input cmd, input size_bytes, output ready);
endinterface

interface rbba_res_if;
	logic                         valid;
	logic                         ready;
	rbba_pkg::status_t            status;
	logic [rbba_pkg::ADDR_W-1:0]  address;
	logic [rbba_pkg::OFS_W-1:0]   free_bytes;
	logic                         wake;

	modport source (output valid, output status, output address, output free_bytes,
		output wake, input ready);
	modport sink   (input valid, input status, input address, input free_bytes,
		input wake, output ready);
endinterface

interface rbba_cfg_if;
	logic                             valid;
	logic                             ready;
	rbba_pkg::cfg_idx_t               index;
	logic [rbba_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### design/ring_buffer_block_allocator.sv
// ring_buffer_block_allocator: contiguous ring allocator with wrap mark
// depends on rbba_pkg and the channel interfaces in rbba_if.sv
//
// Usage:
//   req carries one command (alloc, free, unalloc, reset, take_read) and a
//   byte count, rounded up to 64 bytes. rsp returns exactly one result per
//   command: status, address, free byte count after the command, and wake.
//   cfg writes base_addr (index 0) or capacity_bytes (index 1); a capacity
//   write also clears the ring. cfg is always ready; the user must write it
//   only while no command is in flight; the block does not enforce this.
// Timing:
//   a command is registered in the input register at its transfer, and its
//   result is registered in the result register once that register is free
//   or its result is being taken. One command per cycle is sustained while
//   rsp takes every result; the limit is the combinational state update
//   loop over the offsets and the free count.
// Reset:
//   arst_n clears the ring: offsets zero, wrap mark and free count at the
//   full capacity of 1048576 bytes, base address zero, no result pending.
// Stalls:
//   when rsp is not taken the result holds, one more command can sit in
//   the input register, and req drops ready until the result is taken.
module ring_buffer_block_allocator (
	input  logic             clk,
	input  logic             arst_n,
	rbba_cmd_if.sink         req,
	rbba_res_if.source       rsp,
	rbba_cfg_if.sink         cfg
);

	localparam int OW = rbba_pkg::OFS_W;
	localparam int EW = rbba_pkg::OFS_W + 1;
	localparam logic [EW-1:0] GRAIN_ADD  = EW'(rbba_pkg::GRAIN_BYTES - 1);
	localparam logic [EW-1:0] GRAIN_MASK = ~EW'(rbba_pkg::GRAIN_BYTES - 1);
	localparam logic [OW-1:0] MAX_CAP    = OW'(rbba_pkg::MAX_BYTES);
	localparam logic [OW-1:0] GRAIN_CAP  = OW'(rbba_pkg::GRAIN_BYTES);

	function automatic logic [OW-1:0] add_free(
		input logic [OW-1:0] f,
		input logic [OW-1:0] cap,
		input logic [EW-1:0] n
	);
		logic [OW-1:0] room;
		room = cap - f;
		return (n >= {1'b0, room}) ? cap : f + n[OW-1:0];
	endfunction

	// ring state
	logic [rbba_pkg::ADDR_W-1:0] base_q;
	logic [OW-1:0]               cap_q;
	logic [OW-1:0]               wo_q, ro_q, wm_q, free_q, last_q;
	logic                        waiting_q;

	// input register
	logic                        valid_s1;
	rbba_pkg::cmd_t              cmd_s1;
	logic [rbba_pkg::SIZE_W-1:0] size_s1;

	// result register
	logic                        valid_s2;
	rbba_pkg::status_t           status_s2;
	logic [rbba_pkg::ADDR_W-1:0] addr_s2;
	logic [OW-1:0]               free_s2;
	logic                        wake_s2;

	logic                        advance;

	// next state
	logic [OW-1:0]               wo_n, ro_n, wm_n, free_n, last_n;
	logic                        waiting_n;
	rbba_pkg::status_t           status_n;
	logic [rbba_pkg::ADDR_W-1:0] addr_n;
	logic                        wake_n;

	logic [EW-1:0]               r;
	logic [EW-1:0]               sum;
	logic [OW-1:0]               tail, free1, free_a, cap_w;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign rsp.valid      = valid_s2;
	assign rsp.status     = status_s2;
	assign rsp.address    = addr_s2;
	assign rsp.free_bytes = free_s2;
	assign rsp.wake       = wake_s2;

	// effective capacity of a capacity write
	always_comb begin
		cap_w = cfg.data[OW-1:0];
		if (cap_w > MAX_CAP) begin
			cap_w = MAX_CAP;
		end
		cap_w = cap_w & GRAIN_MASK[OW-1:0];
		if (cap_w == '0) begin
			cap_w = GRAIN_CAP;
		end
	end

	always_comb begin
		r         = ({1'b0, size_s1} + GRAIN_ADD) & GRAIN_MASK;
		sum       = {1'b0, ro_q} + r;
		tail      = '0;
		free1     = free_q;
		free_a    = free_q;
		wo_n      = wo_q;
		ro_n      = ro_q;
		wm_n      = wm_q;
		free_n    = free_q;
		last_n    = last_q;
		waiting_n = waiting_q;
		status_n  = rbba_pkg::STATUS_OK;
		addr_n    = '0;
		wake_n    = 1'b0;
		unique case (cmd_s1)
			rbba_pkg::CMD_ALLOC: begin
				if (r > {1'b0, cap_q}) begin
					status_n = rbba_pkg::STATUS_TOO_BIG;
				end else if (r > {1'b0, free_q}) begin
					status_n  = rbba_pkg::STATUS_RETRY;
					waiting_n = 1'b1;
				end else begin
					// wrap when the tail is too short, giving up the tail bytes
					if (({1'b0, wo_q} + r) > {1'b0, cap_q}) begin
						tail  = cap_q - wo_q;
						free1 = (tail >= free_q) ? '0 : free_q - tail;
						wm_n  = wo_q;
						wo_n  = '0;
					end
					if (r > {1'b0, free1}) begin
						status_n  = rbba_pkg::STATUS_RETRY;
						waiting_n = 1'b1;
						free_n    = free1;
					end else begin
						last_n = wo_n;
						addr_n = base_q + {{(rbba_pkg::ADDR_W-OW){1'b0}}, wo_n};
						wo_n   = wo_n + r[OW-1:0];
						free_n = free1 - r[OW-1:0];
					end
				end
			end
			rbba_pkg::CMD_FREE: begin
				if (sum == {1'b0, wm_q}) begin
					ro_n   = '0;
					free_a = add_free(free_q, cap_q, {1'b0, cap_q - wm_q});
					wm_n   = cap_q;
				end else begin
					ro_n = (sum > {1'b0, cap_q}) ? cap_q : sum[OW-1:0];
				end
				free_n    = add_free(free_a, cap_q, r);
				wake_n    = waiting_q;
				waiting_n = 1'b0;
			end
			rbba_pkg::CMD_UNALLOC: begin
				wo_n   = last_q;
				free_n = add_free(free_q, cap_q, r);
			end
			rbba_pkg::CMD_RESET: begin
				wo_n      = '0;
				ro_n      = '0;
				wm_n      = cap_q;
				free_n    = cap_q;
				waiting_n = 1'b0;
			end
			rbba_pkg::CMD_TAKE_READ: begin
				if (ro_q == wm_q) begin
					ro_n   = '0;
					free_n = add_free(free_q, cap_q, {1'b0, cap_q - wm_q});
					wm_n   = cap_q;
				end
				addr_n = base_q + {{(rbba_pkg::ADDR_W-OW){1'b0}}, ro_n};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			cap_q     <= MAX_CAP;
			wo_q      <= '0;
			ro_q      <= '0;
			wm_q      <= MAX_CAP;
			free_q    <= MAX_CAP;
			last_q    <= '0;
			waiting_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rbba_pkg::CFG_BASE_ADDR: begin
					base_q <= cfg.data;
				end
				rbba_pkg::CFG_CAPACITY: begin
					cap_q     <= cap_w;
					wo_q      <= '0;
					ro_q      <= '0;
					wm_q      <= cap_w;
					free_q    <= cap_w;
					last_q    <= '0;
					waiting_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			wo_q      <= wo_n;
			ro_q      <= ro_n;
			wm_q      <= wm_n;
			free_q    <= free_n;
			last_q    <= last_n;
			waiting_q <= waiting_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1  <= req.cmd;
			size_s1 <= req.size_bytes;
		end
		if (advance) begin
			status_s2 <= status_n;
			addr_s2   <= addr_n;
			free_s2   <= free_n;
			wake_s2   <= wake_n;
		end
	end

	// ring invariants
	assert property (@(posedge clk) disable iff (!arst_n) free_q <= cap_q)
		else $error("free count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) (wo_q <= cap_q) && (wm_q <= cap_q))
		else $error("write offset or wrap mark beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) ro_q <= cap_q)
		else $error("read offset beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != rbba_pkg::STATUS_OK) |-> (rsp.address == '0))
		else $error("refused allocation returned an address");

endmodule

### tb/tb_ring_buffer_block_allocator.sv
// testbench for ring_buffer_block_allocator: directed corner cases, then random
// command traffic over several ring sizes, checked against a ring ledger model
// depends on rbba_pkg, the channel interfaces in rbba_if.sv and the block itself
module tb_ring_buffer_block_allocator;

	localparam int QUIET_LIMIT = 5000;
	localparam int SEG_ITEMS   = 213;

	typedef struct {
		rbba_pkg::status_t                status;
		logic [rbba_pkg::ADDR_W-1:0]      address;
		logic [rbba_pkg::OFS_W-1:0]       free_bytes;
		logic                             wake;
	} alloc_result_t;

	class ring_ledger;
		int unsigned   base;
		int unsigned   ring_size;
		int unsigned   wr_ofs;
		int unsigned   rd_ofs;
		int unsigned   wrap_at;
		int unsigned   free_cnt;
		int unsigned   last_ofs;
		bit            alloc_blocked;
		int            mismatches;
		alloc_result_t owed_results[$];

		function new();
			base = 0;
			mismatches = 0;
			last_ofs = 0;
			fit_capacity(rbba_pkg::MAX_BYTES);
			clear_ring();
		endfunction

		function void fit_capacity(int unsigned raw);
			int unsigned c;
			c = raw & 32'h001F_FFFF;
			if (c > rbba_pkg::MAX_BYTES)
				c = rbba_pkg::MAX_BYTES;
			c -= c % rbba_pkg::GRAIN_BYTES;
			if (c == 0)
				c = rbba_pkg::GRAIN_BYTES;
			ring_size = c;
		endfunction

		function void clear_ring();
			wr_ofs = 0;
			rd_ofs = 0;
			wrap_at = ring_size;
			free_cnt = ring_size;
			alloc_blocked = 1'b0;
		endfunction

		function void give_free(int unsigned n);
			free_cnt = (n >= ring_size - free_cnt) ? ring_size : free_cnt + n;
		endfunction

		// reader crossed the wrap point: reclaim the abandoned tail
		function void pass_mark();
			rd_ofs = 0;
			give_free(ring_size - wrap_at);
			wrap_at = ring_size;
		endfunction

		function void write_reg(rbba_pkg::cfg_idx_t idx,
			logic [rbba_pkg::CFG_DATA_W-1:0] data);
			if (idx == rbba_pkg::CFG_BASE_ADDR) begin
				base = data;
			end else if (idx == rbba_pkg::CFG_CAPACITY) begin
				fit_capacity(data);
				last_ofs = 0;
				clear_ring();
			end
		endfunction

		function alloc_result_t note_command(rbba_pkg::cmd_t c,
			logic [rbba_pkg::SIZE_W-1:0] sz);
			int unsigned   r;
			int unsigned   tail;
			alloc_result_t res;
			r = ((32'(sz) + rbba_pkg::GRAIN_BYTES - 1) / rbba_pkg::GRAIN_BYTES)
				* rbba_pkg::GRAIN_BYTES;
			res.status = rbba_pkg::STATUS_OK;
			res.address = '0;
			res.wake = 1'b0;
			unique case (c)
				rbba_pkg::CMD_ALLOC: begin
					if (r > ring_size) begin
						res.status = rbba_pkg::STATUS_TOO_BIG;
					end else if (r > free_cnt) begin
						res.status = rbba_pkg::STATUS_RETRY;
						alloc_blocked = 1'b1;
					end else begin
						if (wr_ofs + r > ring_size) begin
							wrap_at = wr_ofs;
							wr_ofs = 0;
							tail = ring_size - wrap_at;
							free_cnt = (tail >= free_cnt) ? 0 : free_cnt - tail;
						end
						if (r > free_cnt) begin
							res.status = rbba_pkg::STATUS_RETRY;
							alloc_blocked = 1'b1;
						end else begin
							last_ofs = wr_ofs;
							res.address = base + wr_ofs;
							wr_ofs += r;
							free_cnt -= r;
						end
					end
				end
				rbba_pkg::CMD_FREE: begin
					if (rd_ofs + r == wrap_at)
						pass_mark();
					else
						rd_ofs = (rd_ofs + r > ring_size) ? ring_size : rd_ofs + r;
					give_free(r);
					res.wake = alloc_blocked;
					alloc_blocked = 1'b0;
				end
				rbba_pkg::CMD_UNALLOC: begin
					wr_ofs = last_ofs;
					give_free(r);
				end
				rbba_pkg::CMD_RESET: begin
					clear_ring();
				end
				rbba_pkg::CMD_TAKE_READ: begin
					if (rd_ofs == wrap_at)
						pass_mark();
					res.address = base + rd_ofs;
				end
				default: begin
				end
			endcase
			res.free_bytes = free_cnt[rbba_pkg::OFS_W-1:0];
			owed_results.push_back(res);
			return res;
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t exp;
			if (owed_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none outstanding, status %0d address %h",
					$time, got.status, got.address);
				return;
			end
			exp = owed_results.pop_front();
			if (got.status !== exp.status) begin
				mismatches++;
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, exp.status, got.status);
			end
			if (got.address !== exp.address) begin
				mismatches++;
				$display("%0t: address mismatch, expected %h actual %h",
					$time, exp.address, got.address);
			end
			if (got.free_bytes !== exp.free_bytes) begin
				mismatches++;
				$display("%0t: free_bytes mismatch, expected %0d actual %0d",
					$time, exp.free_bytes, got.free_bytes);
			end
			if (got.wake !== exp.wake) begin
				mismatches++;
				$display("%0t: wake mismatch, expected %b actual %b",
					$time, exp.wake, got.wake);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic moved = 1'b0;
	int   send_idle_pct;
	int   recv_idle_pct;

	ring_ledger                  ledger;
	logic [rbba_pkg::SIZE_W-1:0] live_blocks[$];

	rbba_cmd_if req_if();
	rbba_res_if rsp_if();
	rbba_cfg_if cfg_if();

	ring_buffer_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_cmd(input rbba_pkg::cmd_t c, input logic [rbba_pkg::SIZE_W-1:0] sz,
		output alloc_result_t res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.cmd = c;
		req_if.size_bytes = sz;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		moved = 1'b1;
		res = ledger.note_command(c, sz);
	endtask

	task automatic write_reg(input rbba_pkg::cfg_idx_t idx,
		input logic [rbba_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		moved = 1'b1;
		ledger.write_reg(idx, data);
		if (idx == rbba_pkg::CFG_CAPACITY)
			live_blocks.delete();
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// drop the command channel and wait for every owed result
	task automatic settle();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (ledger.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ring of 256 bytes at a base near the top of the address space
	task automatic run_corner_cases();
		alloc_result_t res;
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd0, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd1, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'h1F_FFFF, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd300, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd128, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd128, res);
		send_cmd(rbba_pkg::CMD_FREE, 21'd64, res);
		// wrap is committed even though the request is then refused
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd128, res);
		send_cmd(rbba_pkg::CMD_FREE, 21'd128, res);
		send_cmd(rbba_pkg::CMD_TAKE_READ, 21'd0, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd256, res);
		send_cmd(rbba_pkg::CMD_TAKE_READ, 21'd0, res);
		send_cmd(rbba_pkg::CMD_FREE, 21'd256, res);
		// read offset stops at the end of the ring, then take_read passes the mark
		send_cmd(rbba_pkg::CMD_FREE, 21'd1024, res);
		send_cmd(rbba_pkg::CMD_TAKE_READ, 21'h1F_FFFF, res);
		send_cmd(rbba_pkg::CMD_UNALLOC, 21'd64, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'd64, res);
		send_cmd(rbba_pkg::CMD_UNALLOC, 21'h1F_FFFF, res);
		send_cmd(rbba_pkg::CMD_RESET, 21'd0, res);
		send_cmd(rbba_pkg::cmd_t'(3'd5), 21'h1F_FFFF, res);
		send_cmd(rbba_pkg::cmd_t'(3'd6), 21'd64, res);
		send_cmd(rbba_pkg::cmd_t'(3'd7), 21'd0, res);
		send_cmd(rbba_pkg::CMD_ALLOC, 21'h10_0000, res);
		send_cmd(rbba_pkg::CMD_FREE, 21'd0, res);
	endtask

	// mostly in-order alloc/free usage, some unalloc and take_read, some noise
	task automatic run_traffic(input int n);
		alloc_result_t               res;
		rbba_pkg::cmd_t              c;
		logic [rbba_pkg::SIZE_W-1:0] sz;
		int unsigned                 span;
		int unsigned                 pick;
		bit                          tidy;
		for (int i = 0; i < n; i++) begin
			span = ($urandom_range(9) < 7) ? ledger.ring_size / 8 : ledger.ring_size;
			sz = rbba_pkg::SIZE_W'($urandom_range(span));
			pick = $urandom_range(99);
			tidy = 1'b1;
			c = rbba_pkg::CMD_ALLOC;
			if (pick < 40) begin
				c = rbba_pkg::CMD_ALLOC;
			end else if (pick < 70) begin
				if (live_blocks.size() != 0) begin
					c = rbba_pkg::CMD_FREE;
					sz = live_blocks[0];
				end
			end else if (pick < 78) begin
				c = rbba_pkg::CMD_TAKE_READ;
				sz = rbba_pkg::SIZE_W'($urandom);
			end else if (pick < 83) begin
				if (live_blocks.size() != 0) begin
					c = rbba_pkg::CMD_UNALLOC;
					sz = live_blocks[$];
				end else begin
					c = rbba_pkg::CMD_TAKE_READ;
				end
			end else if (pick < 85) begin
				c = rbba_pkg::CMD_RESET;
			end else begin
				tidy = 1'b0;
				c = rbba_pkg::cmd_t'(3'($urandom_range(7)));
				if ($urandom_range(1) == 1)
					sz = rbba_pkg::SIZE_W'($urandom);
			end
			send_cmd(c, sz, res);
			if (c == rbba_pkg::CMD_ALLOC && res.status == rbba_pkg::STATUS_OK)
				live_blocks.push_back(sz);
			else if (tidy && c == rbba_pkg::CMD_FREE)
				void'(live_blocks.pop_front());
			else if (tidy && c == rbba_pkg::CMD_UNALLOC)
				void'(live_blocks.pop_back());
			else if (c == rbba_pkg::CMD_RESET)
				live_blocks.delete();
		end
	endtask

	initial begin : result_sink
		alloc_result_t got;
		forever begin
			@(negedge clk);
			rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				moved = 1'b1;
				got.status = rsp_if.status;
				got.address = rsp_if.address;
				got.free_bytes = rsp_if.free_bytes;
				got.wake = rsp_if.wake;
				ledger.check_result(got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (moved)
				quiet = 0;
			else
				quiet++;
			moved = 1'b0;
		end
		$display("ring_buffer_block_allocator test failed");
		$finish;
	end

	initial begin : main
		logic [rbba_pkg::CFG_DATA_W-1:0] cap_raw;
		logic [rbba_pkg::CFG_DATA_W-1:0] base_raw;
		ledger = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = rbba_pkg::CMD_ALLOC;
		req_if.size_bytes = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = rbba_pkg::CFG_BASE_ADDR;
		cfg_if.data = '0;
		send_idle_pct = 15;
		recv_idle_pct = 47;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(rbba_pkg::CFG_BASE_ADDR, 32'hFFFF_FF00);
		write_reg(rbba_pkg::CFG_CAPACITY, 32'd256);
		run_corner_cases();
		settle();

		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 47 : 0;
			recv_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 15 : 0;
			unique case (seg)
				0: begin
					cap_raw = $urandom & 32'hFFE0_0000;
					base_raw = 32'h0000_0000;
				end
				1: begin
					cap_raw = 32'hFFFF_FFFF;
					base_raw = 32'hFFFF_FFFF;
				end
				2: begin
					cap_raw = 32'd1000;
					base_raw = $urandom;
				end
				3: begin
					cap_raw = ($urandom & 32'hFFE0_0000) | 32'd4096;
					base_raw = $urandom;
				end
				4: begin
					cap_raw = 32'd100;
					base_raw = $urandom;
				end
				default: begin
					cap_raw = 32'd1048576;
					base_raw = $urandom;
				end
			endcase
			if (seg % 2 == 0) begin
				write_reg(rbba_pkg::CFG_BASE_ADDR, base_raw);
				write_reg(rbba_pkg::CFG_CAPACITY, cap_raw);
			end else begin
				write_reg(rbba_pkg::CFG_CAPACITY, cap_raw);
				write_reg(rbba_pkg::CFG_BASE_ADDR, base_raw);
			end
			run_traffic(SEG_ITEMS);
			settle();
		end

		repeat (8) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
			$display("ring_buffer_block_allocator test passed");
		else
			$display("ring_buffer_block_allocator test failed");
		$finish;
	end
endmodule
